// ===== hdl/rsn_pkg.sv =====
`timescale 1ns / 1ps

package rsn_pkg;

  // Frame geometry
  localparam int MAX_SOURCE_DIM = 256;
  localparam int DIM_BITS       = $clog2(MAX_SOURCE_DIM);
  localparam int ADDR_BITS      = 2 * DIM_BITS;

  // Fixed-point format
  localparam int FRACTION_BITS = 16;

  // Field widths
  localparam int COEF_W     = 24;
  localparam int OFFS_W     = 32;
  localparam int IDX_W      = 12;
  localparam int SIZE_W     = 9;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Datapath widths: coefficient times zero-extended index, then a three-term sum
  localparam int PROD_W = COEF_W + IDX_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int INT_W  = SUM_W - FRACTION_BITS;

  // Opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COS_COEF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_COEF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ROW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_COL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS = 3'd5;

  // Reset values
  localparam logic signed [COEF_W-1:0] COS_RESET  = COEF_W'(1 << FRACTION_BITS);
  localparam logic [SIZE_W-1:0]        SIZE_RESET = SIZE_W'(256);

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_coef;
    logic signed [COEF_W-1:0] sin_coef;
    logic signed [OFFS_W-1:0] offset_row;
    logic signed [OFFS_W-1:0] offset_col;
    logic [SIZE_W-1:0]        source_rows;
    logic [SIZE_W-1:0]        source_cols;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [PIX_W-1:0]     wdata;
    logic [ADDR_BITS-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic fetch;
    logic outside;
  } rd_tag_t;

endpackage

// ===== hdl/rsn_frame_ram.sv =====
`timescale 1ns / 1ps

module rsn_frame_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rsn_cfg_regs.sv =====
`timescale 1ns / 1ps

module rsn_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [rsn_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [rsn_pkg::CFG_DATA_W-1:0]   wr_data,
  output rsn_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_coef    <= rsn_pkg::COS_RESET;
      cfg.sin_coef    <= '0;
      cfg.offset_row  <= '0;
      cfg.offset_col  <= '0;
      cfg.source_rows <= rsn_pkg::SIZE_RESET;
      cfg.source_cols <= rsn_pkg::SIZE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        rsn_pkg::REG_COS_COEF:    cfg.cos_coef    <= wr_data[rsn_pkg::COEF_W-1:0];
        rsn_pkg::REG_SIN_COEF:    cfg.sin_coef    <= wr_data[rsn_pkg::COEF_W-1:0];
        rsn_pkg::REG_OFFSET_ROW:  cfg.offset_row  <= wr_data[rsn_pkg::OFFS_W-1:0];
        rsn_pkg::REG_OFFSET_COL:  cfg.offset_col  <= wr_data[rsn_pkg::OFFS_W-1:0];
        rsn_pkg::REG_SOURCE_ROWS: cfg.source_rows <= wr_data[rsn_pkg::SIZE_W-1:0];
        rsn_pkg::REG_SOURCE_COLS: cfg.source_cols <= wr_data[rsn_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/rsn_map.sv =====
`timescale 1ns / 1ps

module rsn_map (
  input  logic                           clk,
  input  logic                           rst,
  input  rsn_pkg::cfg_t                  cfg,
  input  logic                           accept,
  input  logic                           opcode,
  input  logic [rsn_pkg::IDX_W-1:0]      row_index,
  input  logic [rsn_pkg::IDX_W-1:0]      col_index,
  input  logic [rsn_pkg::PIX_W-1:0]      pixel_in,
  output rsn_pkg::mem_req_t              mem_req,
  output rsn_pkg::rd_tag_t               rd_tag
);

  typedef struct packed {
    logic                         ok;
    logic [rsn_pkg::DIM_BITS-1:0] idx;
  } coord_t;

  // Stage 1: products
  logic                                 v1;
  logic                                 op1;
  logic                                 ld_ok1;
  logic [rsn_pkg::ADDR_BITS-1:0]        ld_addr1;
  logic [rsn_pkg::PIX_W-1:0]            pix1;
  logic signed [rsn_pkg::PROD_W-1:0]    p_ci;
  logic signed [rsn_pkg::PROD_W-1:0]    p_sj;
  logic signed [rsn_pkg::PROD_W-1:0]    p_cj;
  logic signed [rsn_pkg::PROD_W-1:0]    p_si;

  // Stage 2: sums
  logic                                 v2;
  logic                                 op2;
  logic                                 ld_ok2;
  logic [rsn_pkg::ADDR_BITS-1:0]        ld_addr2;
  logic [rsn_pkg::PIX_W-1:0]            pix2;
  logic signed [rsn_pkg::SUM_W-1:0]     x_sum;
  logic signed [rsn_pkg::SUM_W-1:0]     y_sum;

  logic signed [rsn_pkg::IDX_W:0]       i_s;
  logic signed [rsn_pkg::IDX_W:0]       j_s;
  logic                                 ld_in_range;
  coord_t                               row_c;
  coord_t                               col_c;

  function automatic coord_t map_coord(input logic signed [rsn_pkg::SUM_W-1:0] v,
                                       input logic [rsn_pkg::SIZE_W-1:0] size);
    logic [rsn_pkg::INT_W-1:0]  hi;
    logic                       near_zero;
    logic [rsn_pkg::SIZE_W-1:0] lim;
    coord_t                     c;
    hi        = v[rsn_pkg::SUM_W-1:rsn_pkg::FRACTION_BITS];
    near_zero = (&hi) && (|v[rsn_pkg::FRACTION_BITS-1:0]);
    lim       = (size > rsn_pkg::SIZE_W'(rsn_pkg::MAX_SOURCE_DIM)) ?
                rsn_pkg::SIZE_W'(rsn_pkg::MAX_SOURCE_DIM) : size;
    if (v[rsn_pkg::SUM_W-1]) begin
      // truncation toward zero folds (-1,0) onto index 0
      c.ok  = near_zero && (lim != '0);
      c.idx = '0;
    end else begin
      c.ok  = hi < rsn_pkg::INT_W'(lim);
      c.idx = hi[rsn_pkg::DIM_BITS-1:0];
    end
    return c;
  endfunction

  assign i_s = {1'b0, row_index};
  assign j_s = {1'b0, col_index};
  assign ld_in_range = (row_index < rsn_pkg::IDX_W'(rsn_pkg::MAX_SOURCE_DIM)) &&
                       (col_index < rsn_pkg::IDX_W'(rsn_pkg::MAX_SOURCE_DIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    op1      <= opcode;
    ld_ok1   <= ld_in_range;
    ld_addr1 <= {row_index[rsn_pkg::DIM_BITS-1:0], col_index[rsn_pkg::DIM_BITS-1:0]};
    pix1     <= pixel_in;
    p_ci     <= rsn_pkg::PROD_W'(cfg.cos_coef) * rsn_pkg::PROD_W'(i_s);
    p_sj     <= rsn_pkg::PROD_W'(cfg.sin_coef) * rsn_pkg::PROD_W'(j_s);
    p_cj     <= rsn_pkg::PROD_W'(cfg.cos_coef) * rsn_pkg::PROD_W'(j_s);
    p_si     <= rsn_pkg::PROD_W'(cfg.sin_coef) * rsn_pkg::PROD_W'(i_s);

    op2      <= op1;
    ld_ok2   <= ld_ok1;
    ld_addr2 <= ld_addr1;
    pix2     <= pix1;
    x_sum    <= rsn_pkg::SUM_W'(p_ci) + rsn_pkg::SUM_W'(p_sj) +
                rsn_pkg::SUM_W'(cfg.offset_row);
    y_sum    <= rsn_pkg::SUM_W'(p_cj) - rsn_pkg::SUM_W'(p_si) +
                rsn_pkg::SUM_W'(cfg.offset_col);
  end

  assign row_c = map_coord(x_sum, cfg.source_rows);
  assign col_c = map_coord(y_sum, cfg.source_cols);

  // Loads write and fetches read at the same stage, so program order holds
  assign mem_req.we    = v2 && (op2 == rsn_pkg::OP_LOAD) && ld_ok2;
  assign mem_req.waddr = ld_addr2;
  assign mem_req.wdata = pix2;
  assign mem_req.raddr = {row_c.idx, col_c.idx};

  assign rd_tag.fetch   = v2 && (op2 == rsn_pkg::OP_FETCH);
  assign rd_tag.outside = !(row_c.ok && col_c.ok);

endmodule

// ===== hdl/rotate_scale_nearest_pixel.sv =====
`timescale 1ns / 1ps

// done rises with the result once a fetch beat has passed the product and sum registers and
// the frame read register. Throughput: one beat per cycle, load or fetch; busy stays low.
// A load writes the frame from the sum stage and produces no result beat.
// Reset (rst, synchronous) empties the pipeline and restores the transform registers;
// frame contents are not cleared. Results cannot be stalled by the receiver.
module rotate_scale_nearest_pixel (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode,
  input  logic [rsn_pkg::IDX_W-1:0]       row_index,
  input  logic [rsn_pkg::IDX_W-1:0]       col_index,
  input  logic [rsn_pkg::PIX_W-1:0]       pixel_in,
  // result channel
  output logic                            done,
  output logic [rsn_pkg::PIX_W-1:0]       pixel_out,
  output logic                            outside,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsn_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rsn_pkg::cfg_t     cfg;
  rsn_pkg::mem_req_t mem_req;
  rsn_pkg::rd_tag_t  rd_tag;
  logic              accept;
  logic              outside_q;
  logic [rsn_pkg::PIX_W-1:0] frame_q;

  // The pipeline never backs up, so every beat is taken on arrival.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  rsn_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Multiply, sum, then map to a frame address and issue the memory access.
  rsn_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .opcode    (opcode),
    .row_index (row_index),
    .col_index (col_index),
    .pixel_in  (pixel_in),
    .mem_req   (mem_req),
    .rd_tag    (rd_tag)
  );

  // Source frame, row-major with a stride of the maximum frame width.
  rsn_frame_ram #(
    .DATA_W (rsn_pkg::PIX_W),
    .ADDR_W (rsn_pkg::ADDR_BITS)
  ) u_frame (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (frame_q)
  );

  // Tag travels alongside the registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rd_tag.fetch;
    end
  end

  always_ff @(posedge clk) begin
    outside_q <= rd_tag.outside;
  end

  // Drop the read data for coordinates off the frame.
  assign outside   = outside_q;
  assign pixel_out = outside_q ? '0 : frame_q;

`ifndef ASSERT_OFF
  a_fetch_gives_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (opcode == rsn_pkg::OP_FETCH) |-> ##3 done)
    else $error("fetch beat did not produce a result");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (opcode == rsn_pkg::OP_LOAD) |-> ##3 !done)
    else $error("load beat produced a result");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(rd_tag.fetch))
    else $error("result strobe without a fetch in the pipeline");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    done && outside |-> (pixel_out == '0))
    else $error("outside result carries nonzero pixel");
`endif

endmodule
